@@ rtl/lfhp_pkg.sv @@
// Shared types and constants for the LLC frame header parser.
`default_nettype none

package lfhp_pkg;

   // Longest frame accepted; anything longer is flagged as too long
   localparam int MAX_FRAME_BYTES = 2048;
   // Octet counter saturates at MAX_FRAME_BYTES + 1
   localparam int COUNT_WIDTH     = $clog2(MAX_FRAME_BYTES + 2);
   // Length arithmetic width: room for the counter and for SACK sizes up to 33
   localparam int CALC_WIDTH      = (COUNT_WIDTH > 7) ? COUNT_WIDTH : 7;
   localparam int HEAD_BYTES      = 5;
   localparam int TAIL_BYTES      = 7;
   localparam int LEN_WIDTH       = 11;
   localparam int SEQ_WIDTH       = 9;

   typedef enum logic [2:0] {
      STATUS_OK         = 3'd0,
      STATUS_SHORT      = 3'd1,
      STATUS_PD_SET     = 3'd2,
      STATUS_RSVD_SAPI  = 3'd3,
      STATUS_BAD_U_FUNC = 3'd4,
      STATUS_SACK_LONG  = 3'd5,
      STATUS_TOO_LONG   = 3'd6
   } lfhp_status_type;

   typedef enum logic [1:0] {
      FMT_I  = 2'd0,
      FMT_S  = 2'd1,
      FMT_UI = 2'd2,
      FMT_U  = 2'd3
   } lfhp_format_type;

   typedef enum logic [3:0] {
      FUNC_SABM = 4'd0,
      FUNC_DISC = 4'd1,
      FUNC_UA   = 4'd2,
      FUNC_DM   = 4'd3,
      FUNC_FRMR = 4'd4,
      FUNC_XID  = 4'd5,
      FUNC_NULL = 4'd6,
      FUNC_UI   = 4'd7,
      FUNC_RR   = 4'd8,
      FUNC_ACK  = 4'd9,
      FUNC_SACK = 4'd10,
      FUNC_RNR  = 4'd11
   } lfhp_function_type;

   // Flag bit positions
   localparam int FLAG_CR  = 0;
   localparam int FLAG_AR  = 1;
   localparam int FLAG_PM  = 2;
   localparam int FLAG_ENC = 3;
   localparam int FLAG_MAC = 4;
   localparam int FLAG_PF  = 5;

   // Collected view of one finished frame
   typedef struct packed {
      logic [COUNT_WIDTH-1:0]       count;
      logic [HEAD_BYTES-1:0][7:0]   head;
      logic [TAIL_BYTES-1:0][7:0]   tail;
   } lfhp_frame_type;

   // Decoded header word
   typedef struct packed {
      lfhp_status_type        status;
      logic [3:0]             sapi;
      lfhp_format_type        frame_format;
      lfhp_function_type      frame_function;
      logic [5:0]             flag_bits;
      logic [SEQ_WIDTH-1:0]   send_seq;
      logic [SEQ_WIDTH-1:0]   recv_seq;
      logic [5:0]             sack_bytes;
      logic [LEN_WIDTH-1:0]   payload_offset;
      logic [LEN_WIDTH-1:0]   payload_length;
      logic [23:0]            fcs_value;
      logic [31:0]            mac_value;
   } lfhp_rsp_type;

endpackage

`default_nettype wire

@@ rtl/lfhp_if.sv @@
// Valid/ready channel interfaces for frame octets and decoded header words.
`default_nettype none

interface lfhp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] frame_byte;
   logic       last_byte;

   modport source (output valid, output frame_byte, output last_byte, input ready);
   modport sink   (input valid, input frame_byte, input last_byte, output ready);
endinterface

interface lfhp_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [3:0]  sapi;
   logic [1:0]  frame_format;
   logic [3:0]  frame_function;
   logic [5:0]  flag_bits;
   logic [8:0]  send_seq;
   logic [8:0]  recv_seq;
   logic [5:0]  sack_bytes;
   logic [10:0] payload_offset;
   logic [10:0] payload_length;
   logic [23:0] fcs_value;
   logic [31:0] mac_value;

   modport source (output valid, output status, output sapi, output frame_format,
                   output frame_function, output flag_bits, output send_seq,
                   output recv_seq, output sack_bytes, output payload_offset,
                   output payload_length, output fcs_value, output mac_value,
                   input ready);
   modport sink   (input valid, input status, input sapi, input frame_format,
                   input frame_function, input flag_bits, input send_seq,
                   input recv_seq, input sack_bytes, input payload_offset,
                   input payload_length, input fcs_value, input mac_value,
                   output ready);
endinterface

`default_nettype wire

@@ rtl/llc_frame_header_parser.sv @@
// Top level of the LLC frame header parser: octet collection and result stages.
`default_nettype none

// Takes an LLC frame one octet per word on req_chan, with last_byte set on the
// final FCS octet, and delivers one decoded header word on rsp_chan per frame.
// Octets are accepted one per cycle with no gaps between frames; a new frame
// may start in the cycle after the last octet of the previous one. The final
// octet's frame is latched into a snapshot register and decoded into the
// output register once that register is free; the output register drives
// rsp_chan. The input stalls only while a finished frame waits in the
// snapshot register because the output word has not been taken.

module llc_frame_header_parser (
   input  logic       clock,
   input  logic       reset,
   lfhp_req_if.sink   req_chan,
   lfhp_rsp_if.source rsp_chan
);
   import lfhp_pkg::*;

   logic [COUNT_WIDTH-1:0]     count_ff, count_in;
   logic [HEAD_BYTES-1:0][7:0] head_ff, head_in;
   logic [TAIL_BYTES-1:0][7:0] tail_ff, tail_in;
   lfhp_frame_type             snap_ff, snap_in;
   logic                       snap_valid_ff, snap_valid_in;
   lfhp_rsp_type               rsp_ff, dec_rsp;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       req_fire;
   logic                       rsp_load;

   // Handshake: the decode stage moves when the output register is free
   assign rsp_load       = snap_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !snap_valid_ff || rsp_load;
   assign req_fire       = req_chan.valid && req_chan.ready;

   // Octet collection: count, first five octets, last seven octets
   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      for (int i = 0; i < HEAD_BYTES; i++) begin
         if (count_ff == COUNT_WIDTH'(i)) begin
            head_in[i] = req_chan.frame_byte;
         end
      end
      tail_in = {tail_ff[TAIL_BYTES-2:0], req_chan.frame_byte};
      if (count_ff <= COUNT_WIDTH'(MAX_FRAME_BYTES)) begin
         count_in = count_ff + COUNT_WIDTH'(1);
      end
   end

   assign snap_in.count = count_in;
   assign snap_in.head  = head_in;
   assign snap_in.tail  = tail_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         head_ff  <= '0;
         tail_ff  <= '0;
      end else if (req_fire) begin
         if (req_chan.last_byte) begin
            count_ff <= '0;
            head_ff  <= '0;
            tail_ff  <= '0;
         end else begin
            count_ff <= count_in;
            head_ff  <= head_in;
            tail_ff  <= tail_in;
         end
      end
   end

   // Snapshot of a finished frame
   assign snap_valid_in = (req_fire && req_chan.last_byte) || (snap_valid_ff && !rsp_load);

   always_ff @(posedge clock) begin
      if (reset) begin
         snap_valid_ff <= 1'b0;
      end else begin
         snap_valid_ff <= snap_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && req_chan.last_byte) begin
         snap_ff <= snap_in;
      end
   end

   // Header decode
   lfhp_decode u_decode (
      .frame_i (snap_ff),
      .rsp_o   (dec_rsp)
   );

   // Output register
   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_ff <= dec_rsp;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.status         = rsp_ff.status;
   assign rsp_chan.sapi           = rsp_ff.sapi;
   assign rsp_chan.frame_format   = rsp_ff.frame_format;
   assign rsp_chan.frame_function = rsp_ff.frame_function;
   assign rsp_chan.flag_bits      = rsp_ff.flag_bits;
   assign rsp_chan.send_seq       = rsp_ff.send_seq;
   assign rsp_chan.recv_seq       = rsp_ff.recv_seq;
   assign rsp_chan.sack_bytes     = rsp_ff.sack_bytes;
   assign rsp_chan.payload_offset = rsp_ff.payload_offset;
   assign rsp_chan.payload_length = rsp_ff.payload_length;
   assign rsp_chan.fcs_value      = rsp_ff.fcs_value;
   assign rsp_chan.mac_value      = rsp_ff.mac_value;

   // Checks
   a_count_sat: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_WIDTH'(MAX_FRAME_BYTES + 1))
      else $error("octet counter past saturation");

   a_count_clear: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_chan.last_byte |=> count_ff == '0)
      else $error("counter not cleared after last octet");

   a_snap_src: assert property (@(posedge clock) disable iff (reset)
      $rose(snap_valid_ff) |-> $past(req_fire && req_chan.last_byte))
      else $error("snapshot loaded without a last octet");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.status != STATUS_OK |->
         rsp_ff.sapi == '0 && rsp_ff.mac_value == '0 && rsp_ff.fcs_value == '0 &&
         rsp_ff.payload_length == '0 && rsp_ff.flag_bits == '0)
      else $error("error word carries nonzero fields");

endmodule

`default_nettype wire

@@ rtl/lfhp_decode.sv @@
// Combinational header decoder for one collected LLC frame.
`default_nettype none

module lfhp_decode (
   input  lfhp_pkg::lfhp_frame_type frame_i,
   output lfhp_pkg::lfhp_rsp_type   rsp_o
);
   import lfhp_pkg::*;

   logic [7:0]            addr;
   logic [7:0]            c0, c1, c2, c3;
   logic [CALC_WIDTH-1:0] total;
   logic [CALC_WIDTH-1:0] d0;
   logic [CALC_WIDTH-1:0] d1;
   logic [CALC_WIDTH-1:0] sack_need;
   logic                  rsvd_sapi;
   lfhp_status_type       status;
   lfhp_rsp_type          res;

   assign addr  = frame_i.head[0];
   assign c0    = frame_i.head[1];
   assign c1    = frame_i.head[2];
   assign c2    = frame_i.head[3];
   assign c3    = frame_i.head[4];
   assign total = CALC_WIDTH'(frame_i.count);
   // Octets after the address octet and the three FCS octets
   assign d0    = total - CALC_WIDTH'(4);

   // Reserved SAPI values
   always_comb begin
      unique case (addr[3:0])
         4'd0, 4'd4, 4'd6, 4'd10, 4'd12, 4'd13, 4'd15: rsvd_sapi = 1'b1;
         default:                                       rsvd_sapi = 1'b0;
      endcase
   end

   // I-frame SACK: K octet plus K+1 bitmap octets
   assign sack_need = CALC_WIDTH'({1'b0, c3[4:0]}) + CALC_WIDTH'(2);

   // Main decode
   always_comb begin
      res                  = '0;
      status               = STATUS_OK;
      d1                   = '0;
      res.sapi             = addr[3:0];
      res.fcs_value        = {frame_i.tail[0], frame_i.tail[1], frame_i.tail[2]};
      res.flag_bits[FLAG_PM] = 1'b1;
      res.flag_bits[FLAG_CR] = addr[6];

      priority if (total > CALC_WIDTH'(MAX_FRAME_BYTES)) begin
         status = STATUS_TOO_LONG;
      end else if (total < CALC_WIDTH'(4)) begin
         status = STATUS_SHORT;
      end else if (addr[7]) begin
         status = STATUS_PD_SET;
      end else if (rsvd_sapi) begin
         status = STATUS_RSVD_SAPI;
      end else if (total < CALC_WIDTH'(5)) begin
         status = STATUS_SHORT;
      end else if (!c0[7]) begin
         // I frame
         res.frame_format       = FMT_I;
         res.flag_bits[FLAG_AR] = c0[6];
         res.send_seq           = {c0[4:0], c1[7:4]};
         res.recv_seq           = {c1[2:0], c2[7:2]};
         res.payload_offset     = LEN_WIDTH'(4);
         d1                     = d0 - CALC_WIDTH'(3);
         unique case (c2[1:0])
            2'd0:    res.frame_function = FUNC_RR;
            2'd1:    res.frame_function = FUNC_ACK;
            2'd2:    res.frame_function = FUNC_RNR;
            default: res.frame_function = FUNC_SACK;
         endcase
         if (d0 < CALC_WIDTH'(3)) begin
            status = STATUS_SHORT;
         end else if (c2[1:0] == 2'd3) begin
            if (d1 < sack_need) begin
               status = STATUS_SHORT;
            end else begin
               res.sack_bytes     = {1'b0, c3[4:0]} + 6'd1;
               res.payload_offset = LEN_WIDTH'(CALC_WIDTH'(4) + sack_need);
               res.payload_length = LEN_WIDTH'(d1 - sack_need);
            end
         end else begin
            res.payload_length = LEN_WIDTH'(d1);
         end
      end else if (c0[7:6] == 2'b10) begin
         // S frame
         res.frame_format       = FMT_S;
         res.flag_bits[FLAG_AR] = c0[5];
         res.recv_seq           = {c0[2:0], c1[7:2]};
         d1                     = d0 - CALC_WIDTH'(2);
         unique case (c1[1:0])
            2'd0:    res.frame_function = FUNC_RR;
            2'd1:    res.frame_function = FUNC_ACK;
            2'd2:    res.frame_function = FUNC_RNR;
            default: res.frame_function = FUNC_SACK;
         endcase
         if (d0 < CALC_WIDTH'(2)) begin
            status = STATUS_SHORT;
         end else if (c1[1:0] == 2'd3) begin
            if (d1 < CALC_WIDTH'(1)) begin
               status = STATUS_SHORT;
            end else if (d1 > CALC_WIDTH'(32)) begin
               status = STATUS_SACK_LONG;
            end else begin
               res.sack_bytes = d1[5:0];
            end
         end
      end else if (c0[7:5] == 3'b110) begin
         // UI frame
         res.frame_format        = FMT_UI;
         res.frame_function      = FUNC_UI;
         res.send_seq            = {c0[2:0], c1[7:2]};
         res.payload_offset      = LEN_WIDTH'(3);
         res.flag_bits[FLAG_ENC] = c1[1];
         res.flag_bits[FLAG_PM]  = c1[0];
         d1                      = d0 - CALC_WIDTH'(2);
         if (d0 < CALC_WIDTH'(2)) begin
            status = STATUS_SHORT;
         end else if (c0[4]) begin
            if (d1 < CALC_WIDTH'(4)) begin
               status = STATUS_SHORT;
            end else begin
               res.flag_bits[FLAG_MAC] = 1'b1;
               res.mac_value = {frame_i.tail[3], frame_i.tail[4],
                                frame_i.tail[5], frame_i.tail[6]};
               res.payload_length = LEN_WIDTH'(d1 - CALC_WIDTH'(4));
            end
         end else begin
            res.payload_length = LEN_WIDTH'(d1);
         end
      end else begin
         // U frame; only XID carries an information field
         res.frame_format       = FMT_U;
         res.flag_bits[FLAG_PF] = c0[4];
         d1                     = d0 - CALC_WIDTH'(1);
         unique case (c0[3:0])
            4'h0:    res.frame_function = FUNC_NULL;
            4'h1:    res.frame_function = FUNC_DM;
            4'h4:    res.frame_function = FUNC_DISC;
            4'h6:    res.frame_function = FUNC_UA;
            4'h7:    res.frame_function = FUNC_SABM;
            4'h8:    res.frame_function = FUNC_FRMR;
            4'hb: begin
               res.frame_function = FUNC_XID;
               res.payload_offset = LEN_WIDTH'(2);
               res.payload_length = LEN_WIDTH'(d1);
            end
            default: status = STATUS_BAD_U_FUNC;
         endcase
      end

      // Errors carry status only
      if (status != STATUS_OK) begin
         res = '0;
      end
      res.status = status;
      rsp_o      = res;
   end

endmodule

`default_nettype wire

@@ tb/tb.sv @@
// Self-checking testbench for the LLC frame header parser.
`timescale 1ns / 100ps

module tb;
   import lfhp_pkg::*;

   localparam int CYCLE_LIMIT    = 1000000;
   localparam int RANDOM_OCTETS  = 800;
   localparam int DRAIN_CYCLES   = 10;
   localparam int ADDR_RANDOM    = -1;
   localparam int MAX_PRINTED    = 40;

   // Supervisory function codes in the low control bits of I and S frames
   localparam logic [1:0] SUP_RR   = 2'd0;
   localparam logic [1:0] SUP_ACK  = 2'd1;
   localparam logic [1:0] SUP_RNR  = 2'd2;
   localparam logic [1:0] SUP_SACK = 2'd3;

   // U frame control nibbles
   localparam logic [3:0] U_NULL = 4'h0;
   localparam logic [3:0] U_DM   = 4'h1;
   localparam logic [3:0] U_DISC = 4'h4;
   localparam logic [3:0] U_UA   = 4'h6;
   localparam logic [3:0] U_SABM = 4'h7;
   localparam logic [3:0] U_FRMR = 4'h8;
   localparam logic [3:0] U_XID  = 4'hb;
   localparam logic [3:0] U_BAD  = 4'h2;

   // UI frame variants
   localparam int UI_PLAIN    = 0;
   localparam int UI_WITH_MAC = 1;

   typedef enum int {SHAPE_I, SHAPE_S, SHAPE_UI, SHAPE_U, SHAPE_NOISE} frame_shape_type;

   typedef struct packed {
      logic [7:0] octet;
      logic       last;
      logic       hold;
      logic [7:0] gap;
   } octet_item_type;

   logic clock = 1'b0;
   logic reset;

   lfhp_req_if req_chan ();
   lfhp_rsp_if rsp_chan ();

   llc_frame_header_parser dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Stimulus and scoreboard storage
   octet_item_type pending_octets[$];
   lfhp_rsp_type   expected_headers[$];
   octet_item_type next_octet;
   logic           have_next = 1'b0;
   int             gap_left = 0;
   logic           octet_taken = 1'b0;
   logic           gap_mode = 1'b1;
   logic           stall_mode = 1'b1;
   logic           drain_next = 1'b0;
   int             stall_left = 0;

   // Predictor state for the frame in progress
   int           frame_octets = 0;
   logic [7:0]   head_octets[0:4] = '{default: 8'h00};
   logic [7:0]   tail_octets[0:6] = '{default: 8'h00};

   int           mismatches = 0;
   int           headers_checked = 0;
   int           octets_queued = 0;
   int           octets_taken = 0;
   int           frames_queued = 0;
   int           cycle_count = 0;
   int           status_seen[0:6] = '{default: 0};

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [3:0] pick_sapi();
      case ($urandom_range(0, 8))
         0: return 4'd1;
         1: return 4'd2;
         2: return 4'd3;
         3: return 4'd5;
         4: return 4'd7;
         5: return 4'd8;
         6: return 4'd9;
         7: return 4'd11;
         default: return 4'd14;
      endcase
   endfunction

   function automatic logic [3:0] pick_u_code();
      case ($urandom_range(0, 6))
         0: return U_NULL;
         1: return U_DM;
         2: return U_DISC;
         3: return U_UA;
         4: return U_SABM;
         5: return U_FRMR;
         default: return U_XID;
      endcase
   endfunction

   function automatic lfhp_rsp_type error_header(lfhp_status_type code);
      lfhp_rsp_type hdr;
      hdr = '0;
      hdr.status = code;
      return hdr;
   endfunction

   // Decode the collected frame into the header word the block should give
   function automatic lfhp_rsp_type predict_header();
      lfhp_rsp_type hdr;
      logic [7:0]   a, c0, c1, c2, c3;
      int           left;
      int           sack;
      a  = head_octets[0];
      c0 = head_octets[1];
      c1 = head_octets[2];
      c2 = head_octets[3];
      c3 = head_octets[4];
      hdr = '0;
      if (frame_octets > MAX_FRAME_BYTES) return error_header(STATUS_TOO_LONG);
      if (frame_octets < 4) return error_header(STATUS_SHORT);
      if (a[7]) return error_header(STATUS_PD_SET);
      case (a[3:0])
         4'd0, 4'd4, 4'd6, 4'd10, 4'd12, 4'd13, 4'd15:
            return error_header(STATUS_RSVD_SAPI);
         default: ;
      endcase
      if (frame_octets < 5) return error_header(STATUS_SHORT);

      hdr.status = STATUS_OK;
      hdr.sapi = a[3:0];
      hdr.fcs_value = {tail_octets[0], tail_octets[1], tail_octets[2]};
      hdr.flag_bits[FLAG_PM] = 1'b1;
      hdr.flag_bits[FLAG_CR] = a[6];
      left = frame_octets - 4;

      if (!c0[7]) begin
         // I frame: three control octets, optional K octet and bitmap
         hdr.frame_format = FMT_I;
         if (left < 3) return error_header(STATUS_SHORT);
         left -= 3;
         hdr.flag_bits[FLAG_AR] = c0[6];
         hdr.send_seq = {c0[4:0], c1[7:4]};
         hdr.recv_seq = {c1[2:0], c2[7:2]};
         hdr.payload_offset = 11'd4;
         case (c2[1:0])
            SUP_RR:  hdr.frame_function = FUNC_RR;
            SUP_ACK: hdr.frame_function = FUNC_ACK;
            SUP_RNR: hdr.frame_function = FUNC_RNR;
            default: begin
               hdr.frame_function = FUNC_SACK;
               if (left < 1) return error_header(STATUS_SHORT);
               sack = c3[4:0] + 1;
               if (left < 1 + sack) return error_header(STATUS_SHORT);
               left -= 1 + sack;
               hdr.sack_bytes = sack[5:0];
               hdr.payload_offset = 11'd5 + sack[10:0];
            end
         endcase
         hdr.payload_length = left[LEN_WIDTH-1:0];
      end else if (c0[7:6] == 2'b10) begin
         // S frame: no information field, bitmap fills the rest
         hdr.frame_format = FMT_S;
         if (left < 2) return error_header(STATUS_SHORT);
         left -= 2;
         hdr.flag_bits[FLAG_AR] = c0[5];
         hdr.recv_seq = {c0[2:0], c1[7:2]};
         case (c1[1:0])
            SUP_RR:  hdr.frame_function = FUNC_RR;
            SUP_ACK: hdr.frame_function = FUNC_ACK;
            SUP_RNR: hdr.frame_function = FUNC_RNR;
            default: begin
               hdr.frame_function = FUNC_SACK;
               if (left < 1) return error_header(STATUS_SHORT);
               if (left > 32) return error_header(STATUS_SACK_LONG);
               hdr.sack_bytes = left[5:0];
            end
         endcase
      end else if (c0[7:5] == 3'b110) begin
         // UI frame, MAC sits just before the FCS
         hdr.frame_format = FMT_UI;
         hdr.frame_function = FUNC_UI;
         if (left < 2) return error_header(STATUS_SHORT);
         left -= 2;
         hdr.send_seq = {c0[2:0], c1[7:2]};
         hdr.payload_offset = 11'd3;
         if (c0[4]) begin
            if (left < 4) return error_header(STATUS_SHORT);
            left -= 4;
            hdr.mac_value = {tail_octets[3], tail_octets[4], tail_octets[5], tail_octets[6]};
            hdr.flag_bits[FLAG_MAC] = 1'b1;
         end
         hdr.payload_length = left[LEN_WIDTH-1:0];
         hdr.flag_bits[FLAG_ENC] = c1[1];
         if (!c1[0]) hdr.flag_bits[FLAG_PM] = 1'b0;
      end else begin
         // U frame: only XID carries an information field
         hdr.frame_format = FMT_U;
         left -= 1;
         hdr.flag_bits[FLAG_PF] = c0[4];
         case (c0[3:0])
            U_NULL: hdr.frame_function = FUNC_NULL;
            U_DM:   hdr.frame_function = FUNC_DM;
            U_DISC: hdr.frame_function = FUNC_DISC;
            U_UA:   hdr.frame_function = FUNC_UA;
            U_SABM: hdr.frame_function = FUNC_SABM;
            U_FRMR: hdr.frame_function = FUNC_FRMR;
            U_XID: begin
               hdr.frame_function = FUNC_XID;
               hdr.payload_offset = 11'd2;
               hdr.payload_length = left[LEN_WIDTH-1:0];
            end
            default: return error_header(STATUS_BAD_U_FUNC);
         endcase
      end
      return hdr;
   endfunction

   // Fold one accepted octet into the frame state
   task automatic absorb_octet(logic [7:0] octet, logic last);
      if (frame_octets < 5) head_octets[frame_octets] = octet;
      for (int i = 6; i > 0; i--) tail_octets[i] = tail_octets[i-1];
      tail_octets[0] = octet;
      if (frame_octets <= MAX_FRAME_BYTES) frame_octets++;
      octets_taken++;
      if (last) begin
         expected_headers.push_back(predict_header());
         frame_octets = 0;
         for (int i = 0; i < 5; i++) head_octets[i] = 8'h00;
         for (int i = 0; i < 7; i++) tail_octets[i] = 8'h00;
      end
   endtask

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      mismatches++;
      if (mismatches <= MAX_PRINTED)
         $display("%0t: header %0d %s: got 0x%0h, expected 0x%0h",
                  $realtime, headers_checked, what, got, want);
   endtask

   task automatic check_header();
      lfhp_rsp_type want;
      if (expected_headers.size() == 0) begin
         report_mismatch("arrived with none pending", rsp_chan.status, 0);
      end else begin
         want = expected_headers.pop_front();
         status_seen[want.status]++;
         if (rsp_chan.status !== want.status)
            report_mismatch("status", rsp_chan.status, want.status);
         if (rsp_chan.sapi !== want.sapi)
            report_mismatch("sapi", rsp_chan.sapi, want.sapi);
         if (rsp_chan.frame_format !== want.frame_format)
            report_mismatch("frame_format", rsp_chan.frame_format, want.frame_format);
         if (rsp_chan.frame_function !== want.frame_function)
            report_mismatch("frame_function", rsp_chan.frame_function, want.frame_function);
         if (rsp_chan.flag_bits !== want.flag_bits)
            report_mismatch("flag_bits", rsp_chan.flag_bits, want.flag_bits);
         if (rsp_chan.send_seq !== want.send_seq)
            report_mismatch("send_seq", rsp_chan.send_seq, want.send_seq);
         if (rsp_chan.recv_seq !== want.recv_seq)
            report_mismatch("recv_seq", rsp_chan.recv_seq, want.recv_seq);
         if (rsp_chan.sack_bytes !== want.sack_bytes)
            report_mismatch("sack_bytes", rsp_chan.sack_bytes, want.sack_bytes);
         if (rsp_chan.payload_offset !== want.payload_offset)
            report_mismatch("payload_offset", rsp_chan.payload_offset, want.payload_offset);
         if (rsp_chan.payload_length !== want.payload_length)
            report_mismatch("payload_length", rsp_chan.payload_length, want.payload_length);
         if (rsp_chan.fcs_value !== want.fcs_value)
            report_mismatch("fcs_value", rsp_chan.fcs_value, want.fcs_value);
         if (rsp_chan.mac_value !== want.mac_value)
            report_mismatch("mac_value", rsp_chan.mac_value, want.mac_value);
      end
      headers_checked++;
   endtask

   // Build one frame and queue its octets; cut trims octets off the end
   task automatic make_frame(frame_shape_type shape, int code, int body, int extra, int cut,
                             int addr);
      logic [7:0]     fb[$];
      logic [31:0]    rnd;
      logic [8:0]     seq_a, seq_b;
      octet_item_type item;
      rnd = $urandom;
      seq_a = 9'($urandom);
      seq_b = 9'($urandom);
      if (shape == SHAPE_NOISE) fb.push_back(rnd[7:0]);
      else if (addr < 0) fb.push_back({1'b0, rnd[6], rnd[5:4], pick_sapi()});
      else fb.push_back(addr[7:0]);

      case (shape)
         SHAPE_I: begin
            fb.push_back({1'b0, rnd[8], rnd[13], seq_a[8:4]});
            fb.push_back({seq_a[3:0], rnd[9], seq_b[8:6]});
            fb.push_back({seq_b[5:0], code[1:0]});
            if (code == SUP_SACK) begin
               fb.push_back({rnd[12:10], extra[4:0]});
               for (int i = 0; i <= extra; i++) fb.push_back(8'($urandom_range(0, 255)));
            end
         end
         SHAPE_S: begin
            fb.push_back({2'b10, rnd[8], rnd[11:10], seq_b[8:6]});
            fb.push_back({seq_b[5:0], code[1:0]});
            if (code == SUP_SACK)
               for (int i = 0; i < extra; i++) fb.push_back(8'($urandom_range(0, 255)));
         end
         SHAPE_UI: begin
            fb.push_back({3'b110, code[0], rnd[8], seq_a[8:6]});
            fb.push_back({seq_a[5:0], rnd[9], rnd[10]});
         end
         SHAPE_U: fb.push_back({3'b111, rnd[8], code[3:0]});
         default: ;
      endcase

      // information field, then MAC for UI, then FCS
      for (int i = 0; i < body; i++) fb.push_back(8'($urandom_range(0, 255)));
      if (shape == SHAPE_UI && code == UI_WITH_MAC)
         for (int i = 0; i < 4; i++) fb.push_back(8'($urandom_range(0, 255)));
      for (int i = 0; i < 3; i++) fb.push_back(8'($urandom_range(0, 255)));
      while (cut > 0 && fb.size() > 1) begin
         void'(fb.pop_back());
         cut--;
      end

      foreach (fb[i]) begin
         item.octet = fb[i];
         item.last = (i == fb.size() - 1);
         item.hold = (i == 0) && drain_next;
         item.gap = gap_mode ? 8'(pick_gap()) : 8'd0;
         pending_octets.push_back(item);
      end
      drain_next = 1'b0;
      octets_queued += fb.size();
      frames_queued++;
   endtask

   // Octet sender: a new word once the previous one is taken, after its gap
   always @(negedge clock) begin : octet_drive
      logic present;
      present = 1'b0;
      if (!reset && (!req_chan.valid || octet_taken)) begin
         if (!have_next && pending_octets.size() > 0) begin
            next_octet = pending_octets.pop_front();
            have_next = 1'b1;
            gap_left = next_octet.gap;
         end
         // a held word waits until every header has come back
         if (have_next && !(next_octet.hold && expected_headers.size() > 0)) begin
            if (gap_left > 0) gap_left--;
            else begin
               present = 1'b1;
               have_next = 1'b0;
            end
         end
      end
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else if (!req_chan.valid || octet_taken) begin
         req_chan.valid <= present;
         if (present) begin
            req_chan.frame_byte <= next_octet.octet;
            req_chan.last_byte <= next_octet.last;
         end
      end
   end

   // Header receiver: random stalls when enabled
   always @(negedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else if (stall_left > 0) begin
         rsp_chan.ready <= 1'b0;
         stall_left--;
      end else begin
         rsp_chan.ready <= 1'b1;
         if (stall_mode && $urandom_range(0, 2) == 0) stall_left = pick_gap();
      end
   end

   // Sample both channels at the rising edge
   always @(posedge clock) begin
      octet_taken <= !reset && req_chan.valid && req_chan.ready;
      if (!reset) begin
         if (req_chan.valid && req_chan.ready)
            absorb_octet(req_chan.frame_byte, req_chan.last_byte);
         if (rsp_chan.valid && rsp_chan.ready) check_header();
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout: %0d headers still pending", expected_headers.size());
         $display("** llc_frame_header_parser: FAILED **");
         $finish;
      end
   end

   initial begin : stimulus
      int r;
      int start;
      int shape_cut, shape_addr, shape_body, shape_extra;
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.frame_byte = 8'h00;
      req_chan.last_byte = 1'b0;
      rsp_chan.ready = 1'b0;
      repeat (8) @(negedge clock);
      reset = 1'b0;

      // Directed: length limits and header error order
      make_frame(SHAPE_NOISE, 0, 0, 0, 3, ADDR_RANDOM);         // single octet
      make_frame(SHAPE_I, SUP_RR, 0, 0, 4, ADDR_RANDOM);        // three octets
      make_frame(SHAPE_I, SUP_RR, 0, 0, 3, ADDR_RANDOM);        // four octets
      make_frame(SHAPE_I, SUP_RR, 2, 0, 3, 8'hC1);              // PD set at six octets
      make_frame(SHAPE_I, SUP_RR, 2, 0, 0, 8'h00);              // reserved SAPIs
      make_frame(SHAPE_U, U_SABM, 0, 0, 0, 8'h4F);
      make_frame(SHAPE_S, SUP_RR, 0, 0, 0, 8'h0D);

      // I frames, including SACK bitmaps that do not fit
      make_frame(SHAPE_I, SUP_RR, 5, 0, 0, ADDR_RANDOM);
      make_frame(SHAPE_I, SUP_ACK, 0, 0, 0, ADDR_RANDOM);
      make_frame(SHAPE_I, SUP_RNR, 2, 0, 2, ADDR_RANDOM);       // cut to seven octets, control fits
      make_frame(SHAPE_I, SUP_SACK, 3, 2, 0, ADDR_RANDOM);
      make_frame(SHAPE_I, SUP_SACK, 0, 31, 0, ADDR_RANDOM);
      make_frame(SHAPE_I, SUP_SACK, 0, 3, 1, ADDR_RANDOM);      // bitmap cut short
      make_frame(SHAPE_I, SUP_SACK, 0, 0, 2, ADDR_RANDOM);      // K octet missing

      // S frames: trailing octets ignored, bitmap size limits
      make_frame(SHAPE_S, SUP_ACK, 3, 0, 0, ADDR_RANDOM);
      make_frame(SHAPE_S, SUP_RNR, 0, 0, 1, ADDR_RANDOM);
      make_frame(SHAPE_S, SUP_SACK, 0, 32, 0, ADDR_RANDOM);
      make_frame(SHAPE_S, SUP_SACK, 0, 33, 0, ADDR_RANDOM);
      make_frame(SHAPE_S, SUP_SACK, 0, 0, 0, ADDR_RANDOM);

      // UI frames with and without MAC
      make_frame(SHAPE_UI, UI_PLAIN, 4, 0, 0, ADDR_RANDOM);
      make_frame(SHAPE_UI, UI_WITH_MAC, 2, 0, 0, ADDR_RANDOM);
      make_frame(SHAPE_UI, UI_WITH_MAC, 0, 0, 1, ADDR_RANDOM);
      make_frame(SHAPE_UI, UI_PLAIN, 0, 0, 1, ADDR_RANDOM);

      // U frames: every function but SABM, and one unknown
      make_frame(SHAPE_U, U_NULL, 0, 0, 0, ADDR_RANDOM);
      make_frame(SHAPE_U, U_DM, 3, 0, 0, ADDR_RANDOM);
      make_frame(SHAPE_U, U_DISC, 0, 0, 0, ADDR_RANDOM);
      make_frame(SHAPE_U, U_UA, 0, 0, 0, ADDR_RANDOM);
      make_frame(SHAPE_U, U_FRMR, 0, 0, 0, ADDR_RANDOM);
      make_frame(SHAPE_U, U_XID, 6, 0, 0, ADDR_RANDOM);
      make_frame(SHAPE_U, U_BAD, 0, 0, 0, ADDR_RANDOM);

      // Random frames, mostly well formed; idling style changes every 16 frames
      start = octets_queued;
      while (octets_queued - start < RANDOM_OCTETS) begin
         gap_mode = ((frames_queued / 16) % 3) != 1;
         stall_mode = ((frames_queued / 16) % 3) != 2;
         if (frames_queued % 40 == 20) drain_next = 1'b1;
         shape_cut = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 6) : 0;
         shape_addr = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : ADDR_RANDOM;
         shape_body = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 60)
                                                   : $urandom_range(0, 12);
         r = $urandom_range(0, 99);
         if (r < 30) begin
            shape_extra = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31)
                                                       : $urandom_range(0, 4);
            make_frame(SHAPE_I, $urandom_range(0, 3), shape_body, shape_extra, shape_cut,
                       shape_addr);
         end else if (r < 50) begin
            shape_extra = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 36)
                                                       : $urandom_range(1, 8);
            make_frame(SHAPE_S, $urandom_range(0, 3), $urandom_range(0, 2), shape_extra,
                       shape_cut, shape_addr);
         end else if (r < 70) begin
            make_frame(SHAPE_UI, $urandom_range(0, 1), shape_body, 0, shape_cut, shape_addr);
         end else if (r < 88) begin
            make_frame(SHAPE_U, ($urandom_range(0, 4) == 0) ? $urandom_range(0, 15)
                                                            : pick_u_code(),
                       shape_body, 0, shape_cut, shape_addr);
         end else begin
            make_frame(SHAPE_NOISE, 0, $urandom_range(0, 10), 0, 0, ADDR_RANDOM);
         end
      end

      // Longest legal frame, one octet over, and a saturating one
      gap_mode = 1'b0;
      drain_next = 1'b1;
      make_frame(SHAPE_I, SUP_RR, MAX_FRAME_BYTES - 7, 0, 0, ADDR_RANDOM);
      make_frame(SHAPE_I, SUP_RR, MAX_FRAME_BYTES - 6, 0, 0, ADDR_RANDOM);
      make_frame(SHAPE_UI, UI_WITH_MAC, MAX_FRAME_BYTES + 50, 0, 0, ADDR_RANDOM);
      gap_mode = 1'b1;
      make_frame(SHAPE_U, U_XID, 9, 0, 0, ADDR_RANDOM);

      // Wait for the block to drain, then let it idle before the report
      do @(posedge clock);
      while (pending_octets.size() != 0 || have_next || req_chan.valid ||
             expected_headers.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("run covered %0d frames, %0d octets, %0d headers checked",
               frames_queued, octets_taken, headers_checked);
      $display("statuses ok %0d, short %0d, pd %0d, sapi %0d, u func %0d, sack %0d, long %0d",
               status_seen[0], status_seen[1], status_seen[2], status_seen[3],
               status_seen[4], status_seen[5], status_seen[6]);
      if (mismatches == 0) begin
         $display("** llc_frame_header_parser: PASSED **");
      end else begin
         $display("** llc_frame_header_parser: FAILED **");
      end
      $finish;
   end

endmodule
